/* rtl/fsrs_pkg.sv */
// ----------------------------------------------------------------------------
// fsrs_pkg - flash slot recovery scan definitions
// shared constants, word types and the crc-32 byte update
// ----------------------------------------------------------------------------
package fsrs_pkg;

  localparam int unsigned SLOT_SIZE_DEFAULT = 4096;
  localparam int unsigned SLOT_COUNT        = 16;
  localparam int unsigned HEADER_BYTES      = 16;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_RESET = 32'h536C_6950;

  // input word kinds
  localparam logic [1:0] FUNC_HEADER = 2'd0;
  localparam logic [1:0] FUNC_BYTE   = 2'd1;
  localparam logic [1:0] FUNC_END    = 2'd2;

  // result word kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  slot_index;
    logic [31:0] header_magic;
    logic [31:0] header_seq;
    logic [31:0] header_length;
    logic [31:0] header_crc;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic        result_kind;
    logic [3:0]  verdict_slot;
    logic        slot_valid;
    logic        best_found;
    logic [3:0]  best_slot;
    logic [31:0] best_seq;
    logic [11:0] best_length;
  } result_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

/* rtl/fsrs_engine.sv */
// ----------------------------------------------------------------------------
// fsrs_engine - slot check and best slot tracking
// holds the scan state and works one registered input word per step
// ----------------------------------------------------------------------------
module fsrs_engine #(
  parameter int unsigned SlotSize = fsrs_pkg::SLOT_SIZE_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              step_i,
  input  fsrs_pkg::item_t   item_i,
  output fsrs_pkg::result_t res_o
);

  localparam int unsigned LenW = $clog2(SlotSize);
  localparam logic [31:0] MaxLen = 32'(SlotSize - fsrs_pkg::HEADER_BYTES);

  logic [31:0]     magic_q;
  logic [31:0]     crc_q, crc_d;
  logic [LenW-1:0] bytes_q, bytes_d;
  logic [3:0]      cur_slot_q, cur_slot_d;
  logic [31:0]     cur_seq_q, cur_seq_d;
  logic [LenW-1:0] cur_len_q, cur_len_d;
  logic [31:0]     cur_crc_q, cur_crc_d;
  logic            checking_q, checking_d;
  logic            have_best_q, have_best_d;
  logic [3:0]      best_idx_q, best_idx_d;
  logic [31:0]     best_seq_q, best_seq_d;
  logic [LenW-1:0] best_len_q, best_len_d;

  fsrs_pkg::result_t res_c;
  logic            fin;
  logic            fin_ok;
  logic [3:0]      fin_slot;
  logic [31:0]     fin_seq;
  logic [LenW-1:0] fin_len;
  logic [31:0]     crc_new;
  logic [31:0]     seq_diff;
  logic            ahead;
  logic            take;
  logic            hdr_bad;
  logic            upd_have;
  logic [3:0]      upd_idx;
  logic [31:0]     upd_seq;
  logic [LenW-1:0] upd_len;
  logic [LenW+11:0] len_ext;

  always_comb begin
    crc_d       = crc_q;
    bytes_d     = bytes_q;
    cur_slot_d  = cur_slot_q;
    cur_seq_d   = cur_seq_q;
    cur_len_d   = cur_len_q;
    cur_crc_d   = cur_crc_q;
    checking_d  = checking_q;
    res_c       = '0;
    fin         = 1'b0;
    fin_ok      = 1'b0;
    fin_slot    = cur_slot_q;
    fin_seq     = cur_seq_q;
    fin_len     = cur_len_q;
    crc_new     = fsrs_pkg::crc_byte(crc_q, item_i.data_byte);
    hdr_bad     = (item_i.header_magic != magic_q) ||
                  (32'(item_i.slot_index) >= 32'(fsrs_pkg::SLOT_COUNT)) ||
                  (item_i.header_length > MaxLen);

    case (item_i.func)
      fsrs_pkg::FUNC_HEADER: begin
        cur_slot_d = item_i.slot_index;
        cur_seq_d  = item_i.header_seq;
        cur_crc_d  = item_i.header_crc;
        crc_d      = fsrs_pkg::CRC_INIT;
        bytes_d    = '0;
        checking_d = 1'b0;
        res_c.verdict_slot = item_i.slot_index;
        if (hdr_bad) begin
          cur_len_d   = '0;
          res_c.valid = 1'b1;
        end else begin
          cur_len_d = item_i.header_length[LenW-1:0];
          if (item_i.header_length == 32'h0) begin
            // empty slot, crc of no bytes is zero
            fin         = 1'b1;
            fin_ok      = (item_i.header_crc == 32'h0);
            fin_slot    = item_i.slot_index;
            fin_seq     = item_i.header_seq;
            fin_len     = '0;
            res_c.valid = 1'b1;
          end else begin
            checking_d = 1'b1;
          end
        end
      end
      fsrs_pkg::FUNC_BYTE: begin
        if (checking_q) begin
          crc_d   = crc_new;
          bytes_d = bytes_q + 1'b1;
          res_c.verdict_slot = cur_slot_q;
          if (bytes_d >= cur_len_q) begin
            checking_d  = 1'b0;
            fin         = 1'b1;
            fin_ok      = ((crc_new ^ fsrs_pkg::CRC_INIT) == cur_crc_q);
            res_c.valid = 1'b1;
          end
        end
      end
      fsrs_pkg::FUNC_END: begin
        checking_d        = 1'b0;
        res_c.valid       = 1'b1;
        res_c.result_kind = fsrs_pkg::KIND_SUMMARY;
      end
      default: begin
      end
    endcase

    res_c.slot_valid = fin && fin_ok;
  end

  // wrap-aware newer-than test against the held best slot
  assign seq_diff = fin_seq - best_seq_q;
  assign ahead    = (seq_diff != 32'h0) && !seq_diff[31];
  assign take     = fin && fin_ok && (!have_best_q || ahead);

  assign upd_have = have_best_q || take;
  assign upd_idx  = take ? fin_slot : best_idx_q;
  assign upd_seq  = take ? fin_seq  : best_seq_q;
  assign upd_len  = take ? fin_len  : best_len_q;
  assign len_ext  = {12'h0, upd_len};

  always_comb begin
    if (item_i.func == fsrs_pkg::FUNC_END) begin
      have_best_d = 1'b0;
      best_idx_d  = '0;
      best_seq_d  = '0;
      best_len_d  = '0;
    end else begin
      have_best_d = upd_have;
      best_idx_d  = upd_idx;
      best_seq_d  = upd_seq;
      best_len_d  = upd_len;
    end
  end

  always_comb begin
    res_o             = res_c;
    res_o.best_found  = upd_have;
    res_o.best_slot   = upd_idx;
    res_o.best_seq    = upd_seq;
    res_o.best_length = len_ext[11:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q     <= fsrs_pkg::MAGIC_RESET;
      crc_q       <= fsrs_pkg::CRC_INIT;
      bytes_q     <= '0;
      cur_slot_q  <= '0;
      cur_seq_q   <= '0;
      cur_len_q   <= '0;
      cur_crc_q   <= '0;
      checking_q  <= 1'b0;
      have_best_q <= 1'b0;
      best_idx_q  <= '0;
      best_seq_q  <= '0;
      best_len_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        magic_q <= cfg_data_i;
      end
      if (step_i) begin
        crc_q       <= crc_d;
        bytes_q     <= bytes_d;
        cur_slot_q  <= cur_slot_d;
        cur_seq_q   <= cur_seq_d;
        cur_len_q   <= cur_len_d;
        cur_crc_q   <= cur_crc_d;
        checking_q  <= checking_d;
        have_best_q <= have_best_d;
        best_idx_q  <= best_idx_d;
        best_seq_q  <= best_seq_d;
        best_len_q  <= best_len_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_bytes_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    checking_q |-> (bytes_q < cur_len_q))
    else $error("byte count reached slot length while still checking");

  a_no_best_is_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_best_q |-> (best_seq_q == 32'h0 && best_idx_q == 4'h0 && best_len_q == '0))
    else $error("best slot fields set while no best slot is held");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.func == fsrs_pkg::FUNC_END) |=> (!have_best_q && !checking_q))
    else $error("end of scan left best slot or check active");
`endif

endmodule

/* rtl/flash_slot_recovery_scan.sv */
// ----------------------------------------------------------------------------
// flash_slot_recovery_scan - newest valid flash slot finder
// checks slot headers and content crc-32, keeps the newest valid slot
//
//   channel   dir  words                     fields
//   s_axis    in   header / byte / end       tuser func, tdata header + byte
//   m_axis    out  verdict / summary         tuser kind, tdata verdict + best
//   cfg       in   magic register write      cfg_data_i expected magic
//
// one input word per cycle unless the output stalls; a word is taken into an
// input register and worked from there straight into the output register
// the output register stalls the pipe only while its word waits
// configuration writes complete in the cycle they are offered
// asynchronous reset clears all scan state and restores the reset magic
// ----------------------------------------------------------------------------
module flash_slot_recovery_scan #(
  parameter int unsigned SlotSize = fsrs_pkg::SLOT_SIZE_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot_index[3:0], header_magic[35:4], header_seq[67:36],
  // header_length[99:68], header_crc[131:100], data_byte[139:132], zero pad
  input  logic [143:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // verdict_slot[3:0], slot_valid[4], best_found[5], best_slot[9:6],
  // best_seq[41:10], best_length[53:42], zero pad
  output logic [55:0]  m_axis_tdata,
  // result_kind[0]
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i
);

  fsrs_pkg::item_t   in_q, in_d;
  logic              in_valid_q;
  fsrs_pkg::result_t res;
  fsrs_pkg::result_t out_q;
  logic              out_valid_q;
  logic              advance;
  logic              step;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_d.func          = s_axis_tuser;
    in_d.slot_index    = s_axis_tdata[3:0];
    in_d.header_magic  = s_axis_tdata[35:4];
    in_d.header_seq    = s_axis_tdata[67:36];
    in_d.header_length = s_axis_tdata[99:68];
    in_d.header_crc    = s_axis_tdata[131:100];
    in_d.data_byte     = s_axis_tdata[139:132];
  end

  fsrs_engine #(
    .SlotSize(SlotSize)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .item_i     (in_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.result_kind;
  assign m_axis_tdata  = {2'b00, out_q.best_length, out_q.best_seq, out_q.best_slot,
                          out_q.best_found, out_q.slot_valid, out_q.verdict_slot};

`ifndef NO_ASSERTIONS
  a_end_gives_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_q.func == fsrs_pkg::FUNC_END) |=>
      (out_valid_q && out_q.result_kind == fsrs_pkg::KIND_SUMMARY))
    else $error("end of scan word gave no summary");
`endif

endmodule

/* verif/fsrs_scan_checker.sv */
// ----------------------------------------------------------------------------
// fsrs_scan_checker - result checker for the flash slot recovery scan
// watches the input, result and magic register channels, keeps its own
// model of the slot scan and compares every result word, field by field,
// with the oldest predicted verdict or summary
// ----------------------------------------------------------------------------
module fsrs_scan_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [143:0] in_data_i,
  input  logic [1:0]   in_user_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [55:0]  out_data_i,
  input  logic         out_user_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [31:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic        kind;
    logic [3:0]  vslot;
    logic        ok;
    logic        found;
    logic [3:0]  bslot;
    logic [31:0] bseq;
    logic [11:0] blen;
  } report_t;

  report_t     verdict_q[$];
  report_t     got;
  report_t     want;
  int          errors = 0;

  logic [31:0] magic;
  logic [31:0] crc_run;
  int unsigned nbytes;
  logic [3:0]  cur_slot;
  logic [31:0] cur_seq;
  logic [31:0] cur_len;
  logic [31:0] cur_crc;
  logic        busy;
  logic        held;
  logic [3:0]  best_slot;
  logic [31:0] best_seq;
  logic [31:0] best_len;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ fsrs_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function report_t best_report(input logic k, input logic [3:0] s, input logic ok);
    return '{k, s, ok, held, best_slot, best_seq, best_len[11:0]};
  endfunction

  task close_slot();
    logic [31:0] diff;
    logic        good;
    good = ((crc_run ^ fsrs_pkg::CRC_INIT) == cur_crc);
    busy = 1'b0;
    diff = cur_seq - best_seq;
    // wrap-aware: ahead means a non-zero positive signed difference
    if (good && (!held || (diff != 32'h0 && !diff[31]))) begin
      held      = 1'b1;
      best_slot = cur_slot;
      best_seq  = cur_seq;
      best_len  = cur_len;
    end
    verdict_q.push_back(best_report(fsrs_pkg::KIND_VERDICT, cur_slot, good));
  endtask

  task scan_word(input logic [1:0] fn, input logic [143:0] d);
    logic [3:0]  slot;
    logic [31:0] mg;
    logic [31:0] sq;
    logic [31:0] ln;
    logic [31:0] cr;
    logic [7:0]  b;
    slot = d[3:0];
    mg   = d[35:4];
    sq   = d[67:36];
    ln   = d[99:68];
    cr   = d[131:100];
    b    = d[139:132];
    case (fn)
      fsrs_pkg::FUNC_HEADER: begin
        // a new header drops any unfinished slot
        cur_slot = slot;
        cur_seq  = sq;
        cur_crc  = cr;
        crc_run  = fsrs_pkg::CRC_INIT;
        nbytes   = 0;
        busy     = 1'b0;
        if (mg != magic || 32'(slot) >= fsrs_pkg::SLOT_COUNT ||
            ln > fsrs_pkg::SLOT_SIZE_DEFAULT - fsrs_pkg::HEADER_BYTES) begin
          cur_len = 32'h0;
          verdict_q.push_back(best_report(fsrs_pkg::KIND_VERDICT, slot, 1'b0));
        end else begin
          cur_len = ln;
          if (ln == 32'h0) close_slot();
          else busy = 1'b1;
        end
      end
      fsrs_pkg::FUNC_BYTE: begin
        if (busy) begin
          crc_run = crc_step(crc_run, b);
          nbytes++;
          if (nbytes >= cur_len) close_slot();
        end
      end
      fsrs_pkg::FUNC_END: begin
        busy = 1'b0;
        verdict_q.push_back(best_report(fsrs_pkg::KIND_SUMMARY, 4'h0, 1'b0));
        held      = 1'b0;
        best_slot = 4'h0;
        best_seq  = 32'h0;
        best_len  = 32'h0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic     = fsrs_pkg::MAGIC_RESET;
      crc_run   = fsrs_pkg::CRC_INIT;
      nbytes    = 0;
      cur_slot  = 4'h0;
      cur_seq   = 32'h0;
      cur_len   = 32'h0;
      cur_crc   = 32'h0;
      busy      = 1'b0;
      held      = 1'b0;
      best_slot = 4'h0;
      best_seq  = 32'h0;
      best_len  = 32'h0;
      verdict_q.delete();
      fail_count_o <= errors;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.kind  = out_user_i;
        got.vslot = out_data_i[3:0];
        got.ok    = out_data_i[4];
        got.found = out_data_i[5];
        got.bslot = out_data_i[9:6];
        got.bseq  = out_data_i[41:10];
        got.blen  = out_data_i[53:42];
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result word: kind %0d slot %0d ok %0d found %0d best %0d",
                     got.kind, got.vslot, got.ok, got.found, got.bslot);
          end
        end else begin
          want = verdict_q.pop_front();
          if (got.kind != want.kind || got.vslot != want.vslot || got.ok != want.ok ||
              got.found != want.found || got.bslot != want.bslot ||
              got.bseq != want.bseq || got.blen != want.blen) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected kind %0d slot %0d ok %0d found %0d best %0d",
                       want.kind, want.vslot, want.ok, want.found, want.bslot,
                       " seq %h len %0d", want.bseq, want.blen);
              $display("          actual   kind %0d slot %0d ok %0d found %0d best %0d",
                       got.kind, got.vslot, got.ok, got.found, got.bslot,
                       " seq %h len %0d", got.bseq, got.blen);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) magic = cfg_data_i;
      if (in_valid_i && in_ready_i) scan_word(in_user_i, in_data_i);
      fail_count_o <= errors;
      pending_o    <= verdict_q.size();
    end
  end

endmodule

/* verif/flash_slot_recovery_scan_tb.sv */
// ----------------------------------------------------------------------------
// flash_slot_recovery_scan_tb - testbench for the flash slot recovery scan
// drives directed and random slot scans (good slots, bad magic, oversize
// lengths, corrupt crc, cut-short slots, stray words) under several magic
// settings with random stalls on both channels; a checker beside the block
// predicts and compares every result word
// ----------------------------------------------------------------------------
module flash_slot_recovery_scan_tb;

  localparam int unsigned MaxLen     = fsrs_pkg::SLOT_SIZE_DEFAULT - fsrs_pkg::HEADER_BYTES;
  localparam int unsigned WordBudget = 875;
  localparam logic [1:0]  FuncUnused = 2'd3;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [55:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [31:0]  cfg_data_i;

  int           fail_count;
  int           pending;
  int           useful;
  logic         calm;
  logic [31:0]  magic_now;
  logic [7:0]   content [MaxLen];

  flash_slot_recovery_scan dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  fsrs_scan_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // result side back-pressure
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
    end
  end

  function automatic logic [31:0] crc_of(int unsigned n);
    logic [31:0] c;
    c = fsrs_pkg::CRC_INIT;
    for (int i = 0; i < n; i++) begin
      c = c ^ {24'h0, content[i]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ fsrs_pkg::CRC_POLY) : (c >> 1);
      end
    end
    return c ^ fsrs_pkg::CRC_INIT;
  endfunction

  function automatic fsrs_pkg::item_t random_item();
    fsrs_pkg::item_t w;
    w.func          = 2'($urandom_range(0, 3));
    w.slot_index    = 4'($urandom_range(0, 15));
    w.header_magic  = $urandom;
    w.header_seq    = $urandom;
    w.header_length = $urandom;
    w.header_crc    = $urandom;
    w.data_byte     = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic logic [31:0] near_seq(logic [31:0] base);
    case ($urandom_range(0, 9))
      0: return base + 32'h8000_0000;
      1: return base + 32'h7FFF_FFFF;
      2: return base + 32'h8000_0001;
      3: return $urandom;
      4: return base;
      default: return base + 32'($urandom_range(0, 6)) - 32'd3;
    endcase
  endfunction

  task automatic put_word(input fsrs_pkg::item_t w, input bit counts);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = w.func;
    s_axis_tdata  = {4'h0, w.data_byte, w.header_crc, w.header_length, w.header_seq,
                     w.header_magic, w.slot_index};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (counts) useful++;
  endtask

  task automatic put_header(input logic [3:0] slot, input logic [31:0] magic,
                            input logic [31:0] seq, input logic [31:0] len,
                            input logic [31:0] crc);
    fsrs_pkg::item_t w;
    w               = random_item();
    w.func          = fsrs_pkg::FUNC_HEADER;
    w.slot_index    = slot;
    w.header_magic  = magic;
    w.header_seq    = seq;
    w.header_length = len;
    w.header_crc    = crc;
    put_word(w, 1'b1);
  endtask

  task automatic put_byte(input logic [7:0] b, input bit counts);
    fsrs_pkg::item_t w;
    w           = random_item();
    w.func      = fsrs_pkg::FUNC_BYTE;
    w.data_byte = b;
    put_word(w, counts);
  endtask

  task automatic put_end();
    fsrs_pkg::item_t w;
    w      = random_item();
    w.func = fsrs_pkg::FUNC_END;
    put_word(w, 1'b1);
  endtask

  // header with the current magic, then the first sent bytes of the content
  task automatic put_slot(input logic [3:0] slot, input logic [31:0] seq,
                          input int unsigned len, input bit good, input int unsigned sent);
    logic [31:0] crc;
    for (int i = 0; i < len; i++) content[i] = 8'($urandom_range(0, 255));
    crc = crc_of(len);
    if (!good) crc = crc ^ ($urandom | 32'h1);
    put_header(slot, magic_now, seq, 32'(len), crc);
    for (int i = 0; i < sent; i++) put_byte(content[i], 1'b1);
  endtask

  task automatic set_magic(input logic [31:0] m);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    magic_now   = m;
  endtask

  task automatic random_scan();
    logic [31:0]     base;
    logic [3:0]      slot;
    logic [31:0]     seq;
    int unsigned     len;
    int unsigned     pick;
    fsrs_pkg::item_t w;
    base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFD : $urandom;
    repeat ($urandom_range(1, 6)) begin
      slot = 4'($urandom_range(0, 15));
      seq  = near_seq(base);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 8);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        put_slot(slot, seq, len, $urandom_range(0, 6) != 0, len);
      end else if (pick < 73) begin
        // cut short, the next header or end drops it
        put_slot(slot, seq, len + 1, 1'b1, $urandom_range(0, len));
      end else if (pick < 79) begin
        put_header(slot, magic_now ^ (32'h1 << $urandom_range(0, 31)), seq, 32'(len),
                   $urandom);
        if ($urandom_range(0, 1) == 0) put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 85) begin
        put_header(slot, magic_now, seq,
                   ($urandom_range(0, 1) == 0) ? 32'(MaxLen + 1 + $urandom_range(0, 15))
                                               : ($urandom | 32'h1000),
                   $urandom);
        if ($urandom_range(0, 1) == 0) put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 91) begin
        w      = random_item();
        w.func = ($urandom_range(0, 1) == 0) ? fsrs_pkg::FUNC_BYTE : FuncUnused;
        put_word(w, 1'b0);
      end else if (pick < 96) begin
        put_slot(slot, seq, len + 2, 1'b1, $urandom_range(0, len + 1));
        put_end();
      end else begin
        put_word(random_item(), 1'b1);
      end
    end
    put_end();
  endtask

  initial begin
    fsrs_pkg::item_t w;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = fsrs_pkg::FUNC_HEADER;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 32'h0;
    calm          = 1'b0;
    useful        = 0;
    magic_now     = fsrs_pkg::MAGIC_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part with the reset magic
    put_end();
    w      = random_item();
    w.func = fsrs_pkg::FUNC_BYTE;
    put_word(w, 1'b0);
    w      = random_item();
    w.func = FuncUnused;
    put_word(w, 1'b0);
    put_slot(4'd0, 32'h0, 0, 1'b1, 0);
    put_slot(4'd15, 32'hFFFF_FFFF, 0, 1'b0, 0);
    put_header(4'd3, ~magic_now, 32'd5, 32'd0, 32'd0);
    put_header(4'd4, magic_now, 32'd6, 32'(MaxLen + 1), 32'd0);
    put_header(4'd5, magic_now, 32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_slot(4'd15, 32'hFFFF_FFFF, 2, 1'b1, 2);
    put_slot(4'd1, 32'd1, 1, 1'b1, 1);
    put_slot(4'd2, 32'd1, 0, 1'b1, 0);
    put_slot(4'd6, 32'h8000_0001, 0, 1'b1, 0);
    put_slot(4'd7, 32'h8000_0000, 3, 1'b1, 3);
    put_slot(4'd8, 32'h9000_0000, 3, 1'b1, 1);
    put_slot(4'd9, 32'h9000_0001, 1, 1'b0, 1);
    put_slot(4'd10, 32'h9000_0002, 4, 1'b1, 2);
    put_end();
    put_end();

    // header of the largest content length, cut short by the end word
    put_slot(4'd12, $urandom, MaxLen, 1'b1, 6);
    put_end();

    useful = 0;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       set_magic(32'h0);
        1:       set_magic(32'hFFFF_FFFF);
        4:       set_magic(fsrs_pkg::MAGIC_RESET);
        default: set_magic($urandom);
      endcase
      while (useful < (p + 1) * WordBudget / 5) begin
        calm = (useful > WordBudget * 17 / 20);
        random_scan();
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
